// ----- rtl/rcba_pkg.sv -----
// rcba_pkg: shared widths, codes, state and handshake types for the
// refcounted block allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcba_pkg;

  localparam int MAX_BLOCKS     = 1024;
  localparam int IDX_W          = 10;
  localparam int NUM_W          = 11;
  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_ADDREF  = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clearing;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

  // register value clamped into 1 .. MAX_BLOCKS
  function automatic logic [NUM_W-1:0] eff_blocks(input logic [NUM_W-1:0] n);
    logic [NUM_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = NUM_W'(1);
    end else if (n > NUM_W'(MAX_BLOCKS)) begin
      r = NUM_W'(MAX_BLOCKS);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rcba_ram.sv -----
// rcba_ram: generic single write, single read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rcba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/rcba_ctrl.sv -----
// rcba_ctrl: sequencer for clearing pass, request accept and execute.
// Depends on rcba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcba_ctrl
  import rcba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      cfg_we,
  input  wire dp_stat_t  stat,
  output logic           busy,
  output ctrl_cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
    if (cfg_we) begin
      state_next = S_CLEAR;
    end
  end

  always_comb begin
    cmd.clearing = 1'b0;
    cmd.accept   = 1'b0;
    cmd.exec     = 1'b0;
    busy         = 1'b1;
    unique case (state)
      S_CLEAR: cmd.clearing = 1'b1;
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_EXEC:  cmd.exec = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/rcba_datapath.sv -----
// rcba_datapath: count and link memories, list head, free counter and
// result registers. Depends on rcba_pkg and rcba_ram.
`timescale 1ns / 1ps
`default_nettype none

module rcba_datapath
  import rcba_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctrl_cmd_t        cmd,
  output dp_stat_t              stat,
  input  wire logic [1:0]       mode,
  input  wire logic [IDX_W-1:0] block,
  input  wire logic             cfg_we,
  input  wire logic [NUM_W-1:0] cfg_wdata,
  output logic                  done,
  output logic [1:0]            status,
  output logic [IDX_W-1:0]      block_index,
  output logic                  in_use,
  output logic [NUM_W-1:0]      free_count
);

  logic [NUM_W-1:0] total;
  logic [NUM_W-1:0] n_eff;
  logic [IDX_W-1:0] head, head_next;
  logic [NUM_W-1:0] free, free_next;
  logic [IDX_W-1:0] clr_idx;
  mode_t            mode_q;
  logic [IDX_W-1:0] blk_q;

  logic                  cnt_we, lnk_we;
  logic [IDX_W-1:0]      cnt_waddr, lnk_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [IDX_W-1:0]      lnk_wdata, lnk_rdata;

  logic                  x_cnt_we, x_lnk_we;
  logic [IDX_W-1:0]      x_cnt_waddr;
  logic [COUNT_BITS-1:0] x_cnt_wdata;
  status_t               x_status;
  logic [IDX_W-1:0]      x_bidx;
  logic                  x_inuse;
  logic                  in_range, cnt_zero, cnt_full;

  assign n_eff           = eff_blocks(total);
  assign stat.clear_last = ({1'b0, clr_idx} == (n_eff - NUM_W'(1)));

  rcba_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BLOCKS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (block),
    .rdata (cnt_rdata)
  );

  rcba_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (head),
    .rdata (lnk_rdata)
  );

  // request execution, memory read data valid
  always_comb begin
    in_range    = ({1'b0, blk_q} < n_eff);
    cnt_zero    = (cnt_rdata == '0);
    cnt_full    = &cnt_rdata;
    x_cnt_we    = 1'b0;
    x_lnk_we    = 1'b0;
    x_cnt_waddr = blk_q;
    x_cnt_wdata = cnt_rdata;
    x_status    = ST_OK;
    x_bidx      = '0;
    x_inuse     = 1'b0;
    head_next   = head;
    free_next   = free;
    unique case (mode_q)
      MODE_ALLOC: begin
        if (free == '0) begin
          x_status = ST_NOFREE;
        end else begin
          x_bidx      = head;
          x_cnt_we    = 1'b1;
          x_cnt_waddr = head;
          x_cnt_wdata = COUNT_BITS'(1);
          free_next   = free - NUM_W'(1);
          if (free_next != '0) begin
            head_next = lnk_rdata;
          end
        end
      end
      MODE_ADDREF: begin
        if (!in_range || cnt_zero || cnt_full) begin
          x_status = ST_REJECT;
        end else begin
          x_cnt_we    = 1'b1;
          x_cnt_wdata = cnt_rdata + COUNT_BITS'(1);
        end
      end
      MODE_QUERY: begin
        if (!in_range) begin
          x_status = ST_REJECT;
        end else begin
          x_inuse = !cnt_zero;
        end
      end
      MODE_RELEASE: begin
        if (!in_range || cnt_zero) begin
          x_status = ST_REJECT;
        end else begin
          x_cnt_we    = 1'b1;
          x_cnt_wdata = cnt_rdata - COUNT_BITS'(1);
          if (cnt_rdata == COUNT_BITS'(1)) begin
            x_lnk_we  = 1'b1;
            head_next = blk_q;
            free_next = free + NUM_W'(1);
          end
        end
      end
      default: x_status = ST_REJECT;
    endcase
  end

  // write port select: clearing pass or request
  always_comb begin
    if (cmd.clearing) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx;
      cnt_wdata = '0;
      lnk_we    = 1'b1;
      lnk_waddr = clr_idx;
      lnk_wdata = (clr_idx == '0) ? '0 : clr_idx - IDX_W'(1);
    end else begin
      cnt_we    = cmd.exec & x_cnt_we;
      cnt_waddr = x_cnt_waddr;
      cnt_wdata = x_cnt_wdata;
      lnk_we    = cmd.exec & x_lnk_we;
      lnk_waddr = blk_q;
      lnk_wdata = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= NUM_W'(MAX_BLOCKS);
      head    <= IDX_W'(MAX_BLOCKS - 1);
      free    <= NUM_W'(MAX_BLOCKS);
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cfg_we) begin
        total   <= cfg_wdata;
        head    <= IDX_W'(eff_blocks(cfg_wdata) - NUM_W'(1));
        free    <= eff_blocks(cfg_wdata);
        clr_idx <= '0;
      end else begin
        if (cmd.clearing) begin
          clr_idx <= clr_idx + IDX_W'(1);
        end
        if (cmd.exec) begin
          head <= head_next;
          free <= free_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= mode_t'(mode);
      blk_q  <= block;
    end
    if (cmd.exec) begin
      status      <= x_status;
      block_index <= x_bidx;
      in_use      <= x_inuse;
      free_count  <= free_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/refcounted_block_allocator.sv -----
// refcounted_block_allocator: top level, controller plus datapath.
// Depends on rcba_pkg, rcba_ctrl, rcba_datapath, rcba_ram.
//
// Usage:
//   Request channel: drive mode and block with start high; the word is taken
//   at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with status,
//   block_index, in_use and free_count valid; the receiver cannot stall.
//   Execution: the accepted request runs in the EXEC state, where the count
//   and link memories are written back after their registered read; done and
//   the results load at its end; busy is high, so no new request is taken.
//   Configuration: cfg_we with cfg_wdata writes total_blocks; the user must
//   do so only while idle, the block does not enforce this. It starts a
//   clearing pass over the clamped block count that resets counts and
//   chains the free list; busy stays high meanwhile. Reset: synchronous rst
//   sets total_blocks to 1024 and runs the same clearing pass before any request.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_block_allocator
  import rcba_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       mode,
  input  wire logic [IDX_W-1:0] block,
  output logic                  done,
  output logic [1:0]            status,
  output logic [IDX_W-1:0]      block_index,
  output logic                  in_use,
  output logic [NUM_W-1:0]      free_count,
  input  wire logic             cfg_we,
  input  wire logic [NUM_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rcba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_we (cfg_we),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  rcba_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .block       (block),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .status      (status),
    .block_index (block_index),
    .in_use      (in_use),
    .free_count  (free_count)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a request in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (free_count <= NUM_W'(MAX_BLOCKS)))
    else $error("free count above pool size");

  a_nofree_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NOFREE) |-> (free_count == '0))
    else $error("no free block reported with free blocks left");

endmodule

`default_nettype wire
